FILE: rtl/slsi_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
// Used by slsi_ctrl, slsi_dp and sorted_list_insert_delete; no dependencies.
package slsi_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_FLUSH  = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the accepted request
		logic exec;       // run insert/delete/flush/dump start
		logic dump_step;  // emit head entry and rotate
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // result register can take a new result
		logic dump_go;    // latched request is a dump of a non-empty list
		logic dump_last;  // current dump step emits the final entry
	} stat_t;

endpackage

FILE: rtl/sorted_list_insert_delete.sv
// Top level of the sorted list insert/delete block: stream ports, controller, datapath.
// Depends on slsi_pkg, slsi_ctrl and slsi_dp.
//
//  Port group   Dir  Contents
//  s_axis       in   request: action, value
//  m_axis       out  result: out_value, status, occupancy; tlast = last of request
//
// Insert, delete and flush are a capture, then one compare-and-shift across all
// cells. A dump is a capture, a setup step, then one entry per cycle by rotating
// the cell array while the output is not stalled. One request in flight; a new
// one is taken while the previous result waits. Output stalls hold the datapath.
// Reset clears the count; entries are not cleared.
module sorted_list_insert_delete #(
	parameter int CAPACITY    = slsi_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = slsi_pkg::VALUE_WIDTH_DEF,
	parameter int OCC_W       = $clog2(CAPACITY + 1),
	parameter int IN_W        = ((2 + VALUE_WIDTH + 7) / 8) * 8,
	parameter int OUT_W       = ((VALUE_WIDTH + 2 + OCC_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // action[1:0], value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // out_value, status[1:0], occupancy
	output logic             m_tlast
);
	import slsi_pkg::*;

	cmd_t                          cmd;
	stat_t                         stat;
	logic signed [VALUE_WIDTH-1:0] out_value;
	status_t                       status;
	logic [OCC_W-1:0]              occupancy;

	slsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slsi_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH),
		.CW          (OCC_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.action    (action_t'(s_tdata[1:0])),
		.value     (s_tdata[VALUE_WIDTH+1:2]),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.status    (status),
		.occupancy (occupancy),
		.last      (m_tlast)
	);

	always_comb begin
		m_tdata = '0;
		m_tdata[VALUE_WIDTH-1:0]                        = out_value;
		m_tdata[VALUE_WIDTH+1:VALUE_WIDTH]              = status;
		m_tdata[VALUE_WIDTH+2+OCC_W-1:VALUE_WIDTH+2]    = occupancy;
	end

endmodule

FILE: rtl/slsi_ctrl.sv
// Controller FSM for the sorted list block: sequences capture, execute and dump.
// Depends on slsi_pkg.
module slsi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  slsi_pkg::stat_t stat,
	output slsi_pkg::cmd_t  cmd
);
	import slsi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) state_d = stat.dump_go ? S_DUMP : S_IDLE;
			end
			S_DUMP: begin
				if (stat.out_free && stat.dump_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = stat.out_free;
			end
			S_DUMP: begin
				cmd.dump_step = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	a_exec_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> state_q == S_EXEC)
		else $error("exec issued outside execute state");

	a_dump_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && cmd.dump_step && stat.dump_last) |=> state_q == S_IDLE)
		else $error("dump did not finish after last entry");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.capture)
		else $error("request captured while busy");

endmodule

FILE: rtl/slsi_dp.sv
// Datapath for the sorted list: compare-and-shift cell array, count, result register.
// Depends on slsi_pkg; driven by slsi_ctrl commands.
module slsi_dp #(
	parameter int CAPACITY    = slsi_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = slsi_pkg::VALUE_WIDTH_DEF,
	parameter int CW          = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slsi_pkg::action_t             action,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  slsi_pkg::cmd_t                cmd,
	output slsi_pkg::stat_t               stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [VALUE_WIDTH-1:0] out_value,
	output slsi_pkg::status_t             status,
	output logic [CW-1:0]                 occupancy,
	output logic                          last
);
	import slsi_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	action_t                       act_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic signed [VALUE_WIDTH-1:0] ent_q [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] ent_d [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] ins_in [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] del_in [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] rot_in [CAPACITY];
	logic [CW-1:0]                 count_q, count_d;
	logic [IW-1:0]                 idx_q;
	logic [CAPACITY-1:0]           valid, ins_after, lt, eq;
	logic                          full, found;
	logic                          do_ins, do_del;

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	status_t                       status_q;
	logic [CW-1:0]                 occ_q;
	logic                          last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			val_q <= value;
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid[i]     = CW'(i) < count_q;
			ins_after[i] = !valid[i] || (ent_q[i] > val_q);
			lt[i]        = valid[i] && (ent_q[i] < val_q);
			eq[i]        = valid[i] && (ent_q[i] == val_q);
		end
	end

	assign full   = count_q == CW'(CAPACITY);
	assign found  = |eq;
	assign do_ins = cmd.exec && act_q == ACT_INSERT && !full;
	assign do_del = cmd.exec && act_q == ACT_DELETE && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign ins_in[i] = val_q;
		end else begin : g_body
			assign ins_in[i] = ins_after[i-1] ? ent_q[i-1] : val_q;
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign del_in[i] = ent_q[i];
			assign rot_in[i] = ent_q[0];
		end else begin : g_mid
			assign del_in[i] = ent_q[i+1];
			assign rot_in[i] = (CW'(i + 1) == count_q) ? ent_q[0] : ent_q[i+1];
		end

		always_comb begin
			ent_d[i] = ent_q[i];
			if (do_ins && ins_after[i]) begin
				ent_d[i] = ins_in[i];
			end else if (do_del && valid[i] && !lt[i]) begin
				ent_d[i] = del_in[i];
			end else if (cmd.dump_step) begin
				ent_d[i] = rot_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) count_d = count_q + CW'(1);
		else if (do_del) count_d = count_q - CW'(1);
		else if (cmd.exec && act_q == ACT_FLUSH) count_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.exec) idx_q <= '0;
			else if (cmd.dump_step) idx_q <= idx_q + IW'(1);
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.dump_go   = act_q == ACT_DUMP && count_q != '0;
	assign stat.dump_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !stat.dump_go) || cmd.dump_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !stat.dump_go) begin
			out_value_q <= '0;
			occ_q       <= count_d;
			last_q      <= 1'b1;
			case (act_q)
				ACT_INSERT: status_q <= full ? ST_FULL : ST_OK;
				ACT_DELETE: status_q <= found ? ST_OK : ST_NOT_FOUND;
				ACT_FLUSH:  status_q <= ST_OK;
				ACT_DUMP:   status_q <= ST_EMPTY;
				default:    status_q <= ST_OK;
			endcase
		end else if (cmd.dump_step) begin
			out_value_q <= ent_q[0];
			occ_q       <= count_q;
			last_q      <= stat.dump_last;
			status_q    <= ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign occupancy = occ_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeds capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && act_q == ACT_INSERT && full) |=> count_q == $past(count_q))
		else $error("insert into full list changed count");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_step |-> count_q != '0)
		else $error("dump step on empty list");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.dump_step) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");

endmodule
